FILE: sv/kvt_pkg.sv
// kvt_pkg: shared types and constants of the key/value table
// capacity, field widths, operation and status codes
// no dependencies
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 64;
	localparam int VALUE_W = 64;
	localparam int TOTAL_W = 5;

	typedef logic [1:0] op_t;
	typedef logic [2:0] status_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CAPACITY-1:0] slot_vec_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [TOTAL_W-1:0] total_t;

	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_LOOKUP = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;
	localparam op_t OP_SHIFT = 2'd3;

	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_FULL = 3'd1;
	localparam status_t ST_DUP = 3'd2;
	localparam status_t ST_EMPTY = 3'd3;
	localparam status_t ST_MISSING = 3'd4;

endpackage

FILE: sv/key_value_table.sv
// key_value_table: associative table of 64-bit keys and values in flip-flops
// add, lookup, remove and key shift, one transaction per cycle while the response is not stalled
// depends on kvt_pkg
`timescale 1ns / 1ps

// Usage
// Request channel: req_valid/req_stall with operation, key, value, shift_up.
// Response channel: rsp_valid/rsp_stall with status, found, result_value,
// entry_total. A transaction moves at a rising edge with valid high and
// stall low. Every request gives exactly one response, in order.
// A request taken at one edge sits in the input register, is matched in
// parallel against all CAPACITY slots and is written to the response
// register once that register is empty or its receiver does not stall.
// Throughput is one request per cycle without stalls, set by the parallel
// combinational key compare and table update between the two registers.
// When the receiver stalls the response holds; the input register then
// holds too and req_stall rises, so at most two requests are in flight.
// Reset clears all valid bits, the entry count and both valid flags; key
// and value slots are only read once written.
module key_value_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  kvt_pkg::op_t      operation,
	input  kvt_pkg::key_t     key,
	input  kvt_pkg::value_t   value,
	input  logic              shift_up,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output kvt_pkg::status_t  status,
	output logic              found,
	output kvt_pkg::value_t   result_value,
	output kvt_pkg::total_t   entry_total
);
	import kvt_pkg::*;

	logic      valid_s1;
	op_t       op_s1;
	key_t      key_s1;
	value_t    value_s1;
	logic      up_s1;

	key_t      key_q [CAPACITY];
	value_t    val_q [CAPACITY];
	slot_vec_t used_q;
	cnt_t      cnt_q;

	logic      rsp_valid_q;
	status_t   status_q;
	logic      found_q;
	value_t    result_q;
	total_t    total_q;

	logic      advance;
	logic      fire;

	slot_vec_t match;
	slot_vec_t match_first;
	slot_vec_t free_first;
	slot_vec_t shift_en;
	logic      hit;
	logic      full;
	value_t    rd_value;

	slot_vec_t used_d;
	cnt_t      cnt_d;
	logic      do_add;
	logic      do_shift;
	status_t   status_d;
	logic      found_d;
	value_t    result_d;

	assign advance = !rsp_valid_q || !rsp_stall;
	assign fire = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1 <= operation;
			key_s1 <= key;
			value_s1 <= value;
			up_s1 <= shift_up;
		end
	end

	// parallel compare and slot selection
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = used_q[i] && (key_q[i] == key_s1);
			shift_en[i] = used_q[i] && ($signed(key_q[i]) >= $signed(key_s1));
		end
		match_first = match & (~match + slot_vec_t'(1));
		free_first = ~used_q & (used_q + slot_vec_t'(1));
		for (int i = 0; i < CAPACITY; i++) begin
			rd_value = rd_value | ({VALUE_W{match_first[i]}} & val_q[i]);
		end
		hit = |match;
		full = &used_q;
	end

	always_comb begin
		used_d = used_q;
		cnt_d = cnt_q;
		do_add = 1'b0;
		do_shift = 1'b0;
		status_d = ST_OK;
		found_d = 1'b0;
		result_d = '0;
		case (op_s1)
			OP_ADD: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (hit) begin
					status_d = ST_DUP;
					found_d = 1'b1;
				end else begin
					do_add = 1'b1;
					used_d = used_q | free_first;
					cnt_d = cnt_q + cnt_t'(1);
				end
			end
			OP_LOOKUP: begin
				found_d = hit;
				result_d = rd_value;
			end
			OP_REMOVE: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else if (!hit) begin
					status_d = ST_MISSING;
				end else begin
					found_d = 1'b1;
					result_d = rd_value;
					used_d = used_q & ~match_first;
					cnt_d = cnt_q - cnt_t'(1);
				end
			end
			default: begin
				do_shift = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			used_q <= used_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_add && free_first[i]) begin
					key_q[i] <= key_s1;
					val_q[i] <= value_s1;
				end else if (do_shift && shift_en[i]) begin
					key_q[i] <= up_s1 ? key_q[i] + key_t'(1) : key_q[i] - key_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			found_q <= found_d;
			result_q <= result_d;
			total_q <= total_t'(cnt_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign found = found_q;
	assign result_value = result_q;
	assign entry_total = total_q;

endmodule
